// File: rtl/assert_macros.svh
// assertion helpers included by servo_slew_rate_limiter_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SLR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SLR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/slr_pkg.sv
package slr_pkg;

	localparam int ANGLE_W = 8;
	localparam int RATE_W  = 16;
	localparam int TIME_W  = 32;
	localparam int REM_W   = 20;
	localparam int EQ_W    = 13;
	localparam int Q2_W    = 16;
	localparam int A_W     = RATE_W + EQ_W;
	localparam int Y_W     = RATE_W + REM_W;

	localparam logic [ANGLE_W-1:0] MAX_ANGLE   = 8'd180;
	localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;
	// one above the largest step, enough to flag saturation
	localparam logic [ANGLE_W-1:0] Q_SAT       = 8'd181;

	localparam logic [REM_W:0] MICRO = 21'd1000000;

	// 1e6 = 64 * 15625; divide by 15625 through a reciprocal
	localparam int PRE_SHIFT = 6;
	localparam int K1 = 40;
	localparam logic [26:0] RECIP1 = 27'd70368745;
	localparam int K2 = 44;
	localparam logic [30:0] RECIP2 = 31'd1125899907;

	// one step of work handed from the quotient pipe to the tracker
	typedef struct packed {
		logic                 valid;
		logic                 apply;
		logic [ANGLE_W-1:0]   target;
		logic [ANGLE_W-1:0]   qsat;
		logic [REM_W-1:0]     rem;
	} slr_step_t;

	function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] v);
		clamp_angle = (v > MAX_ANGLE) ? MAX_ANGLE : v;
	endfunction

endpackage

// File: rtl/slr_in_if.sv
interface slr_in_if;
	logic                           valid;
	logic                           ready;
	logic [slr_pkg::ANGLE_W-1:0]    target_angle;
	logic [slr_pkg::RATE_W-1:0]     rate_dps;
	logic [slr_pkg::TIME_W-1:0]     time_us;

	modport source (output valid, output target_angle, output rate_dps, output time_us,
		input ready);
	modport sink (input valid, input target_angle, input rate_dps, input time_us,
		output ready);
endinterface

// File: rtl/slr_out_if.sv
interface slr_out_if;
	logic                           valid;
	logic                           ready;
	logic [slr_pkg::ANGLE_W-1:0]    angle;
	logic                           applied;

	modport source (output valid, output angle, output applied, input ready);
	modport sink (input valid, input angle, input applied, output ready);
endinterface

// File: rtl/servo_slew_rate_limiter_unit.sv
// servo slew-rate limiter
// request channel: target_angle, rate_dps and a free-running microsecond
// time_us stamp; result channel: the new angle and an applied flag.
// cfg_we/cfg_wdata load the servo angle (start angle, clamped to 180) at once;
// write it only while no request is in flight.
// the first request after reset only records its timestamp (applied = 0),
// as does any request whose timestamp equals the previous one.
// throughput: one request per cycle, sustained while the result side is not stalled.
// six stages split rate * elapsed into whole degrees and millionths with
// reciprocal multiplies, and the result register applies the residual and
// moves the angle.
// reset: angle returns to 90, residual and timestamp history clear and the
// pipe empties.
// a stalled result holds the whole pipe and drops request.ready in the same
// cycle; nothing is lost or repeated.
module servo_slew_rate_limiter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [slr_pkg::ANGLE_W-1:0] cfg_wdata,
	slr_in_if.sink                      request,
	slr_out_if.source                   result
);

	`include "assert_macros.svh"

	logic               adv;
	slr_pkg::slr_step_t step;

	slr_step_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.request (request),
		.step    (step)
	);

	slr_angle_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.adv       (adv),
		.result    (result)
	);

	// checks
	`SLR_ASSERT(a_angle_range, result.valid |-> (result.angle <= slr_pkg::MAX_ANGLE), "angle above limit")
	`SLR_ASSERT(a_stall_holds, (result.valid && !result.ready) |-> !request.ready, "request taken during stall")
	`SLR_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !result.valid, "result valid in reset")

endmodule

// File: rtl/slr_step_pipe.sv
module slr_step_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	slr_in_if.sink            request,
	output slr_pkg::slr_step_t step
);

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6;
	logic [slr_pkg::ANGLE_W-1:0] tg_s1, tg_s2, tg_s3, tg_s4, tg_s5, tg_s6;

	logic [slr_pkg::RATE_W-1:0]  rate_s1, rate_s2, rate_s3;
	logic [slr_pkg::TIME_W-1:0]  el_s1, el_s2;
	logic [slr_pkg::EQ_W-1:0]    eq_s2;
	logic [slr_pkg::REM_W-1:0]   er_s3;
	logic [slr_pkg::A_W-1:0]     a_s3, a_s4, a_s5;
	logic [slr_pkg::Y_W-1:0]     y_s4, y_s5;
	logic [slr_pkg::Q2_W-1:0]    q2_s5;
	logic [slr_pkg::ANGLE_W-1:0] qsat_s6;
	logic [slr_pkg::REM_W-1:0]   rem_s6;

	logic                        started_q;
	logic [slr_pkg::TIME_W-1:0]  prev_time_q;

	logic                        take;
	logic [slr_pkg::TIME_W-1:0]  elapsed;
	logic [52:0]                 prod1;
	logic [39:0]                 eqm;
	logic [60:0]                 prod2;
	logic [35:0]                 q2m;
	logic [slr_pkg::A_W:0]       qtot;

	assign request.ready = adv;
	assign take = request.valid && adv;

	// time since the previous request, wraps mod 2^32
	assign elapsed = request.time_us - prev_time_q;

	// quotient estimates by reciprocal multiply
	assign prod1 = 53'(el_s1[slr_pkg::TIME_W-1:slr_pkg::PRE_SHIFT]) * 53'(slr_pkg::RECIP1);
	assign eqm   = 40'(eq_s2) * 40'(slr_pkg::MICRO);
	assign prod2 = 61'(y_s4[slr_pkg::Y_W-1:slr_pkg::PRE_SHIFT]) * 61'(slr_pkg::RECIP2);
	assign q2m   = 36'(q2_s5) * 36'(slr_pkg::MICRO);
	assign qtot  = {1'b0, a_s5} + (slr_pkg::A_W+1)'(q2_s5);

	// timestamp history and first-request tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			prev_time_q <= '0;
		end else if (take) begin
			started_q   <= 1'b1;
			prev_time_q <= request.time_us;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= request.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			ap_s1   <= started_q && (elapsed != '0);
			tg_s1   <= slr_pkg::clamp_angle(request.target_angle);
			rate_s1 <= request.rate_dps;
			el_s1   <= elapsed;

			ap_s2   <= ap_s1;
			tg_s2   <= tg_s1;
			rate_s2 <= rate_s1;
			el_s2   <= el_s1;
			eq_s2   <= prod1[slr_pkg::K1 +: slr_pkg::EQ_W];

			ap_s3   <= ap_s2;
			tg_s3   <= tg_s2;
			rate_s3 <= rate_s2;
			er_s3   <= el_s2[slr_pkg::REM_W-1:0] - eqm[slr_pkg::REM_W-1:0];
			a_s3    <= slr_pkg::A_W'(rate_s2) * slr_pkg::A_W'(eq_s2);

			ap_s4   <= ap_s3;
			tg_s4   <= tg_s3;
			a_s4    <= a_s3;
			y_s4    <= slr_pkg::Y_W'(rate_s3) * slr_pkg::Y_W'(er_s3);

			ap_s5   <= ap_s4;
			tg_s5   <= tg_s4;
			a_s5    <= a_s4;
			y_s5    <= y_s4;
			q2_s5   <= prod2[slr_pkg::K2 +: slr_pkg::Q2_W];

			ap_s6   <= ap_s5;
			tg_s6   <= tg_s5;
			rem_s6  <= y_s5[slr_pkg::REM_W-1:0] - q2m[slr_pkg::REM_W-1:0];
			qsat_s6 <= (qtot > (slr_pkg::A_W+1)'(slr_pkg::Q_SAT)) ? slr_pkg::Q_SAT
				: qtot[slr_pkg::ANGLE_W-1:0];
		end
	end

	assign step.valid  = v_s6;
	assign step.apply  = ap_s6;
	assign step.target = tg_s6;
	assign step.qsat   = qsat_s6;
	assign step.rem    = rem_s6;

endmodule

// File: rtl/slr_angle_track.sv
module slr_angle_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [slr_pkg::ANGLE_W-1:0] cfg_wdata,
	input  slr_pkg::slr_step_t          step,
	output logic                        adv,
	slr_out_if.source                   result
);

	logic [slr_pkg::ANGLE_W-1:0] cur_q;
	logic [slr_pkg::REM_W-1:0]   residual_q;
	logic                        valid_q;
	logic [slr_pkg::ANGLE_W-1:0] angle_q;
	logic                        applied_q;

	logic [slr_pkg::REM_W:0]     sum_r;
	logic                        carry;
	logic [slr_pkg::REM_W-1:0]   rem_next;
	logic [slr_pkg::ANGLE_W:0]   whole;
	logic [slr_pkg::ANGLE_W-1:0] step_deg;
	logic [slr_pkg::ANGLE_W-1:0] diff;
	logic [slr_pkg::ANGLE_W-1:0] next_angle;
	logic                        upward;
	logic                        fire;

	// pipe moves whenever the result register is free or being drained
	assign adv  = !valid_q || result.ready;
	assign fire = adv && step.valid;

	// fold new remainder into residual, carry a whole degree out
	assign sum_r    = {1'b0, residual_q} + {1'b0, step.rem};
	assign carry    = sum_r >= slr_pkg::MICRO;
	assign rem_next = carry ? slr_pkg::REM_W'(sum_r - slr_pkg::MICRO)
		: sum_r[slr_pkg::REM_W-1:0];
	assign whole    = {1'b0, step.qsat} + {{slr_pkg::ANGLE_W{1'b0}}, carry};
	assign step_deg = (whole > {1'b0, slr_pkg::MAX_ANGLE}) ? slr_pkg::MAX_ANGLE
		: whole[slr_pkg::ANGLE_W-1:0];

	// move toward target by at most one step
	assign upward = step.target > cur_q;
	assign diff   = upward ? step.target - cur_q : cur_q - step.target;
	always_comb begin
		if (diff > step_deg) begin
			next_angle = upward ? cur_q + step_deg : cur_q - step_deg;
		end else begin
			next_angle = step.target;
		end
	end

	// angle and residual state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= slr_pkg::ANGLE_RESET;
			residual_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cur_q <= slr_pkg::clamp_angle(cfg_wdata);
			end else if (fire && step.apply) begin
				cur_q      <= next_angle;
				residual_q <= rem_next;
			end
			if (adv) begin
				valid_q <= step.valid;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			angle_q   <= step.apply ? next_angle : cur_q;
			applied_q <= step.apply;
		end
	end

	assign result.valid   = valid_q;
	assign result.angle   = angle_q;
	assign result.applied = applied_q;

endmodule

// File: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_W = slr_pkg::ANGLE_W;
	localparam int RATE_W  = slr_pkg::RATE_W;
	localparam int TIME_W  = slr_pkg::TIME_W;
	localparam int REM_W   = slr_pkg::REM_W;
	localparam logic [ANGLE_W-1:0] MAX_ANGLE   = slr_pkg::MAX_ANGLE;
	localparam logic [ANGLE_W-1:0] ANGLE_RESET = slr_pkg::ANGLE_RESET;
	localparam logic [REM_W:0]     MICRO       = slr_pkg::MICRO;

	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 150;
	localparam int STALL_LIMIT   = 4000;

	typedef struct {
		logic [ANGLE_W-1:0] angle;
		logic               applied;
	} servo_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ANGLE_W-1:0] cfg_wdata;

	slr_in_if  req_if ();
	slr_out_if res_if ();

	servo_slew_rate_limiter_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (req_if),
		.result    (res_if)
	);

	// tracked servo state
	logic [ANGLE_W-1:0] trk_angle;
	logic [TIME_W-1:0]  trk_last_us;
	logic [REM_W-1:0]   trk_resid;
	bit                 trk_started;

	servo_result_t pending_results[$];
	logic [TIME_W-1:0] clock_us;
	int errors;
	int results_seen;
	bit src_gaps_on;
	bit sink_gaps_on;
	bit long_hold_req;
	int hold_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// expected angle after one request, updates the tracked state
	function automatic servo_result_t predict_move(input logic [ANGLE_W-1:0] tgt_raw,
		input logic [RATE_W-1:0] rate, input logic [TIME_W-1:0] now);
		logic [ANGLE_W-1:0] tgt;
		logic [TIME_W-1:0]  dt;
		logic [63:0]        rate64;
		logic [63:0]        dt64;
		logic [63:0]        sum;
		logic [63:0]        whole;
		logic [63:0]        rem64;
		logic [ANGLE_W-1:0] step;
		logic [ANGLE_W-1:0] gap;
		servo_result_t      r;
		tgt = (tgt_raw > MAX_ANGLE) ? MAX_ANGLE : tgt_raw;
		dt = now - trk_last_us;
		r.applied = 1'b0;
		if (!trk_started) begin
			trk_last_us = now;
			trk_started = 1'b1;
		end else if (dt != '0) begin
			rate64 = 64'(rate);
			dt64 = 64'(dt);
			sum = rate64 * dt64 + 64'(trk_resid);
			whole = sum / 64'(MICRO);
			rem64 = sum % 64'(MICRO);
			step = (whole > 64'(MAX_ANGLE)) ? MAX_ANGLE : whole[ANGLE_W-1:0];
			trk_resid = rem64[REM_W-1:0];
			gap = (tgt > trk_angle) ? tgt - trk_angle : trk_angle - tgt;
			if (gap > step) begin
				trk_angle = (tgt > trk_angle) ? trk_angle + step : trk_angle - step;
			end else begin
				trk_angle = tgt;
			end
			trk_last_us = now;
			r.applied = 1'b1;
		end
		r.angle = trk_angle;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
	endtask

	// lower the request valid; n sets how long it stays low
	task automatic pause_source(input int n);
		@(negedge clk);
		req_if.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// offer one request and record its expected result when accepted
	task automatic send_request(input logic [ANGLE_W-1:0] tgt, input logic [RATE_W-1:0] rate,
		input logic [TIME_W-1:0] stamp);
		if (src_gaps_on && $urandom_range(0, 7) == 0) begin
			pause_source(int'($urandom_range(1, 13)));
		end
		@(negedge clk);
		req_if.valid        <= 1'b1;
		req_if.target_angle <= tgt;
		req_if.rate_dps     <= rate;
		req_if.time_us      <= stamp;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		pending_results.push_back(predict_move(tgt, rate, stamp));
	endtask

	// stop offering and wait until every result is back and the pipe is quiet
	task automatic drain;
		pause_source(1);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_angle(input logic [ANGLE_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		trk_angle = (value > MAX_ANGLE) ? MAX_ANGLE : value;
	endtask

	// random request: mostly small time steps, some zero, some anywhere
	task automatic send_random_request;
		logic [ANGLE_W-1:0] tgt;
		logic [RATE_W-1:0]  rate;
		int pick;
		pick = int'($urandom_range(0, 99));
		if (pick < 8) begin
			clock_us = clock_us;
		end else if (pick < 70) begin
			clock_us = clock_us + $urandom_range(1, 20000);
		end else if (pick < 88) begin
			clock_us = clock_us + $urandom_range(1, 1 << 22);
		end else begin
			clock_us = $urandom;
		end
		pick = int'($urandom_range(0, 99));
		tgt = ANGLE_W'((pick < 85) ? $urandom_range(0, 180) : $urandom_range(181, 255));
		pick = int'($urandom_range(0, 99));
		if (pick < 6) begin
			rate = '0;
		end else if (pick < 50) begin
			rate = RATE_W'($urandom_range(0, 400));
		end else if (pick < 80) begin
			rate = RATE_W'($urandom_range(0, 8000));
		end else begin
			rate = RATE_W'($urandom);
		end
		send_request(tgt, rate, clock_us);
	endtask

	// first request only records time, equal stamps change nothing
	task automatic test_first_and_zero_elapsed;
		clock_us = 32'h0000_1000;
		send_request(8'd0, 16'd1000, clock_us);
		send_request(8'd0, 16'd1000, clock_us);
		clock_us = clock_us + 32'd1000;
		send_request(8'd0, 16'd1000, clock_us);
		clock_us = clock_us + 32'd1999;
		send_request(8'd180, 16'd500, clock_us);
		clock_us = clock_us + 32'd1;
		send_request(8'd180, 16'd500, clock_us);
		send_request(8'd180, 16'd500, clock_us);
	endtask

	// saturated steps, timestamp wrap and field extremes
	task automatic test_saturation_and_wrap;
		clock_us = 32'hFFFF_FFF0;
		send_request(8'd255, 16'hFFFF, clock_us);
		clock_us = 32'h0000_0010;
		send_request(8'd0, 16'hFFFF, clock_us);
		clock_us = clock_us + 32'hFFFF_FFFF;
		send_request(8'd0, 16'hFFFF, clock_us);
		clock_us = 32'hFFFF_FFFF;
		send_request(8'd180, 16'd1, clock_us);
		clock_us = 32'h0000_0000;
		send_request(8'd181, 16'hFFFF, clock_us);
	endtask

	// residual builds without moving, zero rate adds nothing
	task automatic test_zero_rate;
		clock_us = clock_us + 32'd999_999;
		send_request(8'd0, 16'd1, clock_us);
		clock_us = clock_us + 32'h8000_0000;
		send_request(8'd0, 16'd0, clock_us);
		clock_us = clock_us + 32'd1;
		send_request(8'd0, 16'd1, clock_us);
		clock_us = clock_us + 32'd12345;
		send_request(8'd90, 16'd0, clock_us);
	endtask

	// start angle loads the servo angle at once, above 180 is clamped
	task automatic test_start_angle;
		write_start_angle(8'd0);
		clock_us = clock_us + 32'd5000;
		send_request(8'd180, 16'd200, clock_us);
		write_start_angle(8'd180);
		clock_us = clock_us + 32'd5000;
		send_request(8'd0, 16'd200, clock_us);
		write_start_angle(8'd255);
		clock_us = clock_us + 32'd3000;
		send_request(8'd100, 16'd2000, clock_us);
		write_start_angle(8'd90);
		send_request(8'd100, 16'd2000, clock_us);
	endtask

	// random requests over several start angles with random gaps
	task automatic test_random_mix;
		logic [ANGLE_W-1:0] starts [5];
		starts[0] = ANGLE_W'($urandom_range(0, 180));
		starts[1] = 8'd255;
		starts[2] = 8'd180;
		starts[3] = 8'd0;
		starts[4] = ANGLE_W'($urandom_range(0, 255));
		for (int p = 0; p < 5; p++) begin
			write_start_angle(starts[p]);
			for (int i = 0; i < 140; i++) begin
				if (i % 25 == 0) begin
					src_gaps_on  = ($urandom_range(0, 3) != 0);
					sink_gaps_on = ($urandom_range(0, 3) != 0);
				end
				send_random_request();
			end
		end
	endtask

	// result side holds off long while requests keep coming
	task automatic test_backpressure;
		drain();
		src_gaps_on  = 1'b0;
		sink_gaps_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (60) send_random_request();
		drain();
	endtask

	// back-to-back traffic, no idling on either side
	task automatic test_streaming;
		src_gaps_on  = 1'b0;
		sink_gaps_on = 1'b0;
		write_start_angle(ANGLE_W'($urandom_range(0, 255)));
		repeat (190) send_random_request();
	endtask

	// result ready: random bursts of hold-off, or one long stretch on request
	always @(negedge clk) begin
		if (long_hold_req) begin
			hold_left = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else if (sink_gaps_on && $urandom_range(0, 9) == 0) begin
			hold_left = int'($urandom_range(0, 12));
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin : check_results
		servo_result_t want;
		if (res_if.valid && res_if.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", int'(res_if.angle), -1);
			end else begin
				want = pending_results.pop_front();
				if (res_if.angle !== want.angle) begin
					report_mismatch("angle", int'(res_if.angle), int'(want.angle));
				end
				if (res_if.applied !== want.applied) begin
					report_mismatch("applied", int'(res_if.applied), int'(want.applied));
				end
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_if.valid        = 1'b0;
		req_if.target_angle = '0;
		req_if.rate_dps     = '0;
		req_if.time_us      = '0;
		res_if.ready        = 1'b0;
		errors        = 0;
		results_seen  = 0;
		hold_left     = 0;
		long_hold_req = 1'b0;
		src_gaps_on   = 1'b1;
		sink_gaps_on  = 1'b1;
		clock_us      = '0;
		trk_angle     = ANGLE_RESET;
		trk_last_us   = '0;
		trk_resid     = '0;
		trk_started   = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_and_zero_elapsed();
		test_saturation_and_wrap();
		test_zero_rate();
		test_start_angle();
		test_random_mix();
		test_backpressure();
		test_streaming();
		drain();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/slr_pkg.sv
rtl/slr_in_if.sv
rtl/slr_out_if.sv
rtl/slr_step_pipe.sv
rtl/slr_angle_track.sv
rtl/servo_slew_rate_limiter_unit.sv
dv/tb.sv
